/* rtl/core/twss_pkg.sv */
package twss_pkg;

    localparam logic [23:0] ELAPSED_MAX = 24'hFF_FFFF;

    localparam logic [15:0] STEPS_PER_REV_RST = 16'd200;
    localparam logic [23:0] STEP_INTERVAL_RST = 24'd5000;

    typedef enum logic [1:0] {
        REG_STEPS_PER_REV = 2'd0,
        REG_STEP_INTERVAL = 2'd1,
        REG_REVERSE       = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] move_steps;
    } in_item_t;

    typedef struct packed {
        logic        coil_a;
        logic        coil_b;
        logic [15:0] position;
        logic [15:0] left_count;
        logic        stepped;
    } out_item_t;

    typedef struct packed {
        logic [15:0] steps_per_rev;
        logic [23:0] step_interval;
        logic        reverse;
    } twss_cfg_t;

    typedef struct packed {
        logic [15:0] position;
        logic        forward;
        logic [15:0] remaining;
        logic [23:0] elapsed;
    } twss_state_t;

endpackage

/* rtl/core/twss_motion.sv */
module twss_motion
    import twss_pkg::*;
(
    input  in_item_t    item,
    input  twss_cfg_t   cfg,
    input  twss_state_t cur,
    output twss_state_t nxt,
    output out_item_t   result
);

    logic        neg;
    logic [15:0] raw;
    logic [15:0] mag;
    logic [23:0] elapsed_inc;
    logic        fire;
    logic [15:0] rev_len;
    logic [16:0] pos_up;
    logic [15:0] pos_fwd;
    logic [15:0] pos_back;
    logic [1:0]  phase;

    assign raw = item.move_steps;
    assign neg = raw[15];
    // most negative move wraps to 16'h8000, which is the right magnitude
    assign mag = neg ? (~raw + 16'd1) : raw;

    assign elapsed_inc = (cur.elapsed == ELAPSED_MAX) ? cur.elapsed : cur.elapsed + 24'd1;
    assign fire = (elapsed_inc >= cfg.step_interval) && (cur.remaining != 16'd0);

    // a zero revolution length behaves as one step per revolution
    assign rev_len  = (cfg.steps_per_rev == 16'd0) ? 16'd1 : cfg.steps_per_rev;
    assign pos_up   = {1'b0, cur.position} + 17'd1;
    assign pos_fwd  = (pos_up >= {1'b0, rev_len}) ? 16'd0 : pos_up[15:0];
    assign pos_back = (cur.position == 16'd0 || cur.position >= rev_len)
                      ? rev_len - 16'd1 : cur.position - 16'd1;

    always_comb
    begin
        nxt = cur;
        if (item.cmd)
        begin
            nxt.remaining = mag;
            if (raw != 16'd0)
            begin
                nxt.forward = ~neg ^ cfg.reverse;
            end
        end
        else
        begin
            nxt.elapsed = elapsed_inc;
            if (fire)
            begin
                nxt.position  = cur.forward ? pos_fwd : pos_back;
                nxt.elapsed   = '0;
                nxt.remaining = cur.remaining - 16'd1;
            end
        end
    end

    assign phase = nxt.position[1:0];

    always_comb
    begin
        result.coil_a     = phase[1] ^ phase[0];
        result.coil_b     = phase[1];
        result.position   = nxt.position;
        result.left_count = nxt.remaining;
        result.stepped    = ~item.cmd & fire;
    end

endmodule

/* rtl/core/two_wire_stepper_sequencer.sv */
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-----------------------------
// in       | input     | in_valid / in_stall   | in_data   (in_item_t)
// out      | output    | out_valid / out_stall | out_data  (out_item_t)
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per clock while in_stall is low. State and the result are
// updated in the same cycle by a single pass of combinational logic from
// the motion registers to the output register (or to the skid while it is held).
// A two-entry output buffer (output register plus skid) keeps in_stall
// registered; in_stall rises only when both entries are full.
// rst_n clears config to defaults, position/direction/count to zero and
// saturates the elapsed counter.
module two_wire_stepper_sequencer
    import twss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,

    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    twss_cfg_t   cfg_reg;
    twss_state_t state_reg;
    twss_state_t state_next;
    out_item_t   result;
    out_item_t   out_data_reg;
    out_item_t   skid_data_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        in_take;
    logic        out_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_take   = in_valid & ~skid_valid_reg;
    assign out_take  = out_valid_reg & ~out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_rev <= STEPS_PER_REV_RST;
            cfg_reg.step_interval <= STEP_INTERVAL_RST;
            cfg_reg.reverse       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STEPS_PER_REV: cfg_reg.steps_per_rev <= cfg_data[15:0];
                REG_STEP_INTERVAL: cfg_reg.step_interval <= cfg_data;
                REG_REVERSE:       cfg_reg.reverse       <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    twss_motion u_motion (
        .item   (in_data),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.position  <= '0;
            state_reg.forward   <= 1'b0;
            state_reg.remaining <= '0;
            state_reg.elapsed   <= ELAPSED_MAX;
        end
        else if (in_take)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (!out_valid_reg || out_take)
            begin
                // refill the output from the skid first, then from the new request
                out_valid_reg  <= skid_valid_reg | in_take;
                skid_valid_reg <= skid_valid_reg & in_take;
            end
            else
            begin
                skid_valid_reg <= skid_valid_reg | in_take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (in_take)
                begin
                    skid_data_reg <= result;
                end
            end
            else if (in_take)
            begin
                out_data_reg <= result;
            end
        end
        else if (in_take)
        begin
            skid_data_reg <= result;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_remaining_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.remaining <= 16'h8000)
        else $error("remaining step count exceeds largest move");

    a_step_clears_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && result.stepped) |=> (state_reg.elapsed == 24'd0))
        else $error("elapsed counter not cleared after a step");

    a_cmd_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && in_data.cmd) |=> !$changed(state_reg.position))
        else $error("move command changed position");

    a_step_drops_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && result.stepped)
        |=> (state_reg.remaining == $past(state_reg.remaining) - 16'd1))
        else $error("step did not drop remaining count");

endmodule

/* tb/tb_two_wire_stepper_sequencer.sv */
`timescale 1ns / 100ps

module tb_two_wire_stepper_sequencer;
    import twss_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    two_wire_stepper_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor copy of the registers and the motion state
    logic [15:0] cfg_spr = STEPS_PER_REV_RST;
    logic [23:0] cfg_interval = STEP_INTERVAL_RST;
    logic        cfg_reverse = 1'b0;

    logic [15:0] motor_pos = '0;
    logic        motor_fwd = 1'b0;
    logic [15:0] motor_left = '0;
    logic [23:0] motor_elapsed = ELAPSED_MAX;

    in_item_t    motion_requests[$];
    out_item_t   expected_drive[$];

    logic        idle_on = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          error_count = 0;
    int          tick_count = 0;
    int          move_count = 0;
    int          step_count = 0;
    int          reg_writes = 0;

    function automatic out_item_t advance_motor(in_item_t req);
        logic [15:0] mag;
        int          n;
        int          nxt;
        out_item_t   res;
        res = '0;
        if (req.cmd) begin
            mag = req.move_steps[15] ? (~req.move_steps + 16'd1) : req.move_steps;
            motor_left = mag;
            if (req.move_steps != 0)
                motor_fwd = ~req.move_steps[15] ^ cfg_reverse;
        end
        else begin
            if (motor_elapsed != ELAPSED_MAX)
                motor_elapsed = motor_elapsed + 24'd1;
            if (motor_elapsed >= cfg_interval && motor_left != 0) begin
                n = (cfg_spr == 0) ? 1 : int'(cfg_spr);
                if (motor_fwd) begin
                    nxt = int'(motor_pos) + 1;
                    motor_pos = (nxt >= n) ? 16'd0 : 16'(nxt);
                end
                else if (motor_pos == 0 || int'(motor_pos) >= n)
                    motor_pos = 16'(n - 1);
                else
                    motor_pos = motor_pos - 16'd1;
                motor_elapsed = '0;
                motor_left = motor_left - 16'd1;
                res.stepped = 1'b1;
            end
        end
        res.coil_a = (motor_pos[1:0] == 2'd1) || (motor_pos[1:0] == 2'd2);
        res.coil_b = motor_pos[1];
        res.position = motor_pos;
        res.left_count = motor_left;
        return res;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // request driver
    always @(posedge clk) begin : drive_requests
        logic busy;
        if (rst_n) begin
            busy = in_valid;
            if (in_valid && !in_stall) begin
                expected_drive.push_back(advance_motor(in_data));
                if (in_data.cmd)
                    move_count++;
                else
                    tick_count++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (motion_requests.size() > 0) begin
                    in_data <= motion_requests.pop_front();
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 8);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : watch_results
        out_item_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_drive.size() == 0) begin
                    $display("[%0t] result with nothing expected", $realtime);
                    error_count++;
                end
                else begin
                    want = expected_drive.pop_front();
                    if (out_data.coil_a !== want.coil_a)
                        flag_mismatch("coil_a", 32'(out_data.coil_a), 32'(want.coil_a));
                    if (out_data.coil_b !== want.coil_b)
                        flag_mismatch("coil_b", 32'(out_data.coil_b), 32'(want.coil_b));
                    if (out_data.position !== want.position)
                        flag_mismatch("position", 32'(out_data.position),
                                      32'(want.position));
                    if (out_data.left_count !== want.left_count)
                        flag_mismatch("left_count", 32'(out_data.left_count),
                                      32'(want.left_count));
                    if (out_data.stepped !== want.stepped)
                        flag_mismatch("stepped", 32'(out_data.stepped), 32'(want.stepped));
                    if (want.stepped)
                        step_count++;
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 9) == 0)
                    recv_gap = $urandom_range(1, 8);
            end
        end
    end

    // call right after a rising edge; returns right after a rising edge
    task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_STEPS_PER_REV: cfg_spr = val[15:0];
            REG_STEP_INTERVAL: cfg_interval = val;
            REG_REVERSE:       cfg_reverse = val[0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_motor(logic [15:0] spr, logic [23:0] ivl, logic rv);
        write_reg(REG_STEPS_PER_REV, {8'd0, spr});
        write_reg(REG_STEP_INTERVAL, ivl);
        write_reg(REG_REVERSE, {23'd0, rv});
    endtask

    task automatic queue_tick();
        in_item_t req;
        req.cmd = 1'b0;
        req.move_steps = 16'($urandom);
        motion_requests.push_back(req);
    endtask

    task automatic queue_move(logic signed [15:0] steps);
        in_item_t req;
        req.cmd = 1'b1;
        req.move_steps = steps;
        motion_requests.push_back(req);
    endtask

    // hold until every request is through and every result is back
    task automatic wait_drained();
        do @(posedge clk);
        while (motion_requests.size() != 0 || in_valid || expected_drive.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    initial begin : stimulus
        logic [15:0] spr;
        logic [23:0] ivl;
        int          mag;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturated elapsed counter against the longest interval
        write_reg(REG_STEP_INTERVAL, ELAPSED_MAX);
        queue_tick();
        queue_move(16'sd2);
        queue_tick();
        queue_tick();
        queue_move(-16'sd1);
        queue_tick();
        wait_drained();

        // zero interval, wrap backward through zero, zero move
        set_motor(16'd200, 24'd0, 1'b0);
        queue_move(-16'sd3);
        repeat (3) queue_tick();
        queue_move(16'sd0);
        queue_tick();
        wait_drained();

        // position beyond a lowered revolution, reversed sign, extreme moves
        set_motor(16'd4, 24'd0, 1'b1);
        queue_move(-16'sd1);
        queue_tick();
        queue_move(16'sd32767);
        repeat (3) queue_tick();
        queue_move(-16'sd32768);
        queue_tick();
        queue_move(16'sd0);
        queue_tick();
        wait_drained();

        // zero steps per revolution acts as one
        set_motor(16'd0, 24'd1, 1'b0);
        queue_move(-16'sd1);
        queue_tick();
        queue_move(16'sd2);
        repeat (2) queue_tick();
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin spr = 16'hFFFF; ivl = 24'd3; end
                1: begin spr = 16'd1; ivl = 24'd0; end
                2: begin spr = 16'd200; ivl = ELAPSED_MAX; end
                default: begin
                    case ($urandom_range(0, 3))
                        0: spr = 16'($urandom_range(1, 8));
                        1: spr = 16'($urandom_range(0, 400));
                        2: spr = 16'(65535 - $urandom_range(0, 3));
                        default: spr = 16'($urandom_range(2, 5));
                    endcase
                    ivl = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 30))
                                                      : 24'($urandom_range(0, 4));
                end
            endcase
            set_motor(spr, ivl, (p == 1) ? 1'b1 : 1'($urandom));
            idle_on = (p != 7);
            for (int i = 0; i < 205; i++) begin
                if ($urandom_range(0, 4) != 0) begin
                    queue_tick();
                end
                else begin
                    case ($urandom_range(0, 9))
                        0: queue_move(16'($urandom));
                        1, 2: begin
                            mag = $urandom_range(0, 300);
                            queue_move($urandom_range(0, 1) ? 16'(mag) : 16'(-mag));
                        end
                        default: begin
                            mag = $urandom_range(0, 12);
                            queue_move($urandom_range(0, 1) ? 16'(mag) : 16'(-mag));
                        end
                    endcase
                end
            end
            wait_drained();
        end

        $display("covered %0d ticks and %0d moves, %0d steps taken", tick_count, move_count,
                 step_count);
        $display("%0d register writes across zero, unit, large and wrapping settings",
                 reg_writes);
        if (error_count == 0)
            $display("tb_two_wire_stepper_sequencer: done, clean");
        else
            $display("tb_two_wire_stepper_sequencer: done, errors");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("timeout with %0d results outstanding", expected_drive.size());
        $display("tb_two_wire_stepper_sequencer: done, errors");
        $finish;
    end

endmodule
